// ===== hw/rtl/lkv_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic
    {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } action_t;

    typedef struct packed
    {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed
    {
        logic shift;
        logic valid;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/lkv_cell.sv =====
// One recency position of the cache: holds an entry and compares its key.
`timescale 1ns / 1ps

module lkv_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lkv_pkg::cell_ctrl_t               ctrl,
    input  lkv_pkg::entry_t                   prev_entry,
    input  logic signed [lkv_pkg::KEY_W-1:0]  probe_key,
    output lkv_pkg::entry_t                   entry,
    output logic                              valid,
    output logic                              hit
);
    import lkv_pkg::*;

    entry_t entry_reg;
    logic   valid_reg;

    // The entry from the more recent neighbour moves down one place.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            entry_reg <= prev_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl.valid;
        end
    end

    assign hit   = valid_reg && (entry_reg.key == probe_key);
    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the fully associative key-value cache with LRU replacement.
`timescale 1ns / 1ps

// Entries are kept in a row of cells ordered by recency, the most recent in
// cell 0. Each item (get or put) is compared against every cell in the cycle
// in which it is accepted; a hit entry or a new key enters cell 0 while the
// cells in front of it move down one place, and an eviction simply drops the
// least recent valid cell. The result is held in an output register, so one
// item is taken every clock cycle while results are drained, and req_ready
// falls only while a result waits on rsp_ready. Capacity is taken from the
// configuration register, with zero treated as one and values above the
// number of cells treated as the number of cells.
module lru_key_value_cache
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]         cfg_wdata,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              action,
    input  logic signed [lkv_pkg::KEY_W-1:0]  lookup_key,
    input  logic signed [lkv_pkg::VAL_W-1:0]  store_value,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              found,
    output logic signed [lkv_pkg::VAL_W-1:0]  read_value,
    output logic                              evicted
);
    import lkv_pkg::*;

    logic [CAP_W-1:0]        capacity_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    rsp_valid_reg;
    logic                    found_reg;
    logic signed [VAL_W-1:0] read_value_reg;
    logic                    evicted_reg;

    entry_t                  cell_entry [ENTRIES];
    entry_t                  cell_prev  [ENTRIES];
    cell_ctrl_t              cell_ctrl  [ENTRIES];
    logic [ENTRIES-1:0]      cell_valid;
    logic [ENTRIES-1:0]      hit_vec;

    logic                    accept;
    logic                    any_hit;
    logic                    is_put;
    logic                    put_miss;
    logic                    evict;
    logic [CMP_W-1:0]        eff_cap;
    logic signed [VAL_W-1:0] hit_value;
    entry_t                  front_entry;

    assign accept    = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign is_put    = (action_t'(action) == ACT_PUT);
    assign any_hit   = |hit_vec;
    assign put_miss  = is_put && !any_hit;

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(capacity_reg) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(capacity_reg);
        end
    end

    // With the store full, the least recent entry falls off the end of the
    // valid run, so the count stays as it is.
    assign evict = put_miss && (CMP_W'(count_reg) >= eff_cap);

    always_comb
    begin
        count_next = count_reg;
        if (accept && put_miss && !evict)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Keys are unique among valid cells, so at most one cell hits.
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_vec[i])
            begin
                hit_value = hit_value | cell_entry[i].value;
            end
        end
    end

    always_comb
    begin
        front_entry.key   = lookup_key;
        front_entry.value = is_put ? store_value : hit_value;
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            cell_prev[i]       = (i == 0) ? front_entry : cell_entry[(i == 0) ? 0 : i - 1];
            cell_ctrl[i].shift = accept && (put_miss || (|(hit_vec >> i)));
            cell_ctrl[i].valid = (CNT_W'(i) < count_next);
        end
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lkv_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[g]),
            .prev_entry (cell_prev[g]),
            .probe_key  (lookup_key),
            .entry      (cell_entry[g]),
            .valid      (cell_valid[g]),
            .hit        (hit_vec[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg      <= any_hit;
            evicted_reg    <= evict;
            if (is_put)
            begin
                read_value_reg <= '0;
            end
            else if (any_hit)
            begin
                read_value_reg <= hit_value;
            end
            else
            begin
                read_value_reg <= MISS_VALUE;
            end
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;
    assign evicted    = evicted_reg && (cell_valid != '0);

endmodule

// ===== verif/lru_key_value_cache_test.sv =====
// Self-checking testbench for the LRU key-value cache, with a shadow model in a scoreboard.
`timescale 1ns / 1ps

module lru_key_value_cache_test;
    import lkv_pkg::*;

    typedef struct packed
    {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
    } cache_reply_t;

    class lru_scoreboard;
        logic [KEY_W-1:0] keys[ENTRIES];
        logic [VAL_W-1:0] values[ENTRIES];
        bit               valid[ENTRIES];
        int unsigned      rank[ENTRIES];
        int unsigned      count;
        logic [CAP_W-1:0] capacity;
        cache_reply_t     pending_replies[$];
        int unsigned      errors;
        int unsigned      gets;
        int unsigned      puts;
        int unsigned      hits;
        int unsigned      evictions;

        function new();
            foreach (valid[j])
            begin
                valid[j] = 1'b0;
                rank[j]  = 0;
            end
            count     = 0;
            capacity  = CAP_RESET;
            errors    = 0;
            gets      = 0;
            puts      = 0;
            hits      = 0;
            evictions = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        // Works out the reply to one accepted item and updates the shadow store.
        function void note_request(action_t act, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] val);
            cache_reply_t reply;
            int           hit;
            int           slot;
            int unsigned  limit;
            int unsigned  old_rank;
            reply = '0;
            hit   = -1;
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (valid[j] && keys[j] == key)
                begin
                    hit = j;
                    break;
                end
            end
            if (act == ACT_GET)
                gets++;
            else
                puts++;
            if (hit >= 0)
            begin
                reply.found = 1'b1;
                hits++;
                old_rank = rank[hit];
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (valid[j] && rank[j] < old_rank)
                        rank[j]++;
                end
                rank[hit] = 0;
                if (act == ACT_GET)
                    reply.read_value = values[hit];
                else
                    values[hit] = val;
            end
            else if (act == ACT_GET)
            begin
                reply.read_value = MISS_VALUE;
            end
            else
            begin
                // A capacity of zero behaves as one; anything above the cell count saturates.
                limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
                slot  = -1;
                if (count < limit)
                begin
                    for (int j = 0; j < ENTRIES; j++)
                    begin
                        if (!valid[j])
                        begin
                            slot = j;
                            break;
                        end
                    end
                end
                if (slot < 0)
                begin
                    for (int j = 0; j < ENTRIES; j++)
                    begin
                        if (valid[j] && (slot < 0 || rank[j] > rank[slot]))
                            slot = j;
                    end
                    if (slot < 0)
                        slot = 0;
                    if (valid[slot])
                    begin
                        valid[slot] = 1'b0;
                        if (count > 0)
                            count--;
                        reply.evicted = 1'b1;
                        evictions++;
                    end
                end
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (valid[j])
                        rank[j]++;
                end
                keys[slot]   = key;
                values[slot] = val;
                valid[slot]  = 1'b1;
                rank[slot]   = 0;
                count++;
            end
            pending_replies.push_back(reply);
        endfunction

        function void check_response(logic f, logic signed [VAL_W-1:0] rd, logic ev);
            cache_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with nothing outstanding: found=%0b value=%0d evicted=%0b",
                         $time, f, rd, ev);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (f !== want.found)
            begin
                $display("%0t: found mismatch: expected %0b, got %0b", $time, want.found, f);
                errors++;
            end
            if (rd !== want.read_value)
            begin
                $display("%0t: read_value mismatch: expected %0d, got %0d",
                         $time, want.read_value, rd);
                errors++;
            end
            if (ev !== want.evicted)
            begin
                $display("%0t: evicted mismatch: expected %0b, got %0b",
                         $time, want.evicted, ev);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CAP_W-1:0]        cfg_wdata;
    logic                    req_valid;
    logic                    req_ready;
    logic                    action;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] store_value;
    logic                    rsp_valid;
    logic                    rsp_ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;

    lru_scoreboard sb;
    bit            steady;
    bit            stall_request;
    int unsigned   settings_used;

    lru_key_value_cache i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .action      (action),
        .lookup_key  (lookup_key),
        .store_value (store_value),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .found       (found),
        .read_value  (read_value),
        .evicted     (evicted)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d replies outstanding.", sb.pending_replies.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random back-pressure, plus one long hold-off when asked for.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                stall_left    = 40;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= steady || ($urandom_range(99) >= 24);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(action_t'(action), lookup_key, store_value);
            if (rsp_valid && rsp_ready)
                sb.check_response(found, read_value, evicted);
        end
    end

    task automatic send_item(action_t act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        while (!steady && $urandom_range(99) < 24)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        action      <= act;
        lookup_key  <= key;
        store_value <= val;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_for_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] c);
        wait_for_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_capacity(c);
        settings_used++;
    endtask

    // Mostly keys from a small set, so that hits, updates and evictions all occur.
    task automatic run_phase(int n, int pool_size);
        logic [KEY_W-1:0] pool[32];
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        action_t          act;
        for (int i = 0; i < pool_size; i++)
        begin
            case ($urandom_range(9))
                0:       pool[i] = 32'h8000_0000;
                1:       pool[i] = 32'h7FFF_FFFF;
                2:       pool[i] = '0;
                3:       pool[i] = '1;
                default: pool[i] = $urandom;
            endcase
        end
        for (int i = 0; i < n; i++)
        begin
            act = $urandom_range(1) ? ACT_PUT : ACT_GET;
            key = ($urandom_range(19) == 0) ? $urandom : pool[$urandom_range(pool_size - 1)];
            val = ($urandom_range(15) == 0) ? '1 : $urandom;
            send_item(act, key, val);
        end
    endtask

    initial
    begin
        sb            = new();
        steady        = 1'b0;
        stall_request = 1'b0;
        settings_used = 0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        req_valid   <= 1'b0;
        action      <= 1'b0;
        lookup_key  <= '0;
        store_value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset capacity: miss on an empty store, extreme keys and values, hits and updates.
        send_item(ACT_GET, 32'd0,        32'd77);
        send_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(ACT_PUT, 32'd0,        32'hFFFF_FFFF);
        send_item(ACT_PUT, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(ACT_GET, 32'd0,        32'd0);
        send_item(ACT_GET, 32'd12345,    32'd0);
        send_item(ACT_PUT, 32'h7FFF_FFFF, 32'd5);
        send_item(ACT_GET, 32'h7FFF_FFFF, 32'hAAAA_5555);
        send_item(ACT_GET, 32'hFFFF_FFFF, 32'd0);

        // Capacity dropped below the number held: each new key evicts exactly one entry.
        set_capacity(5'd1);
        send_item(ACT_PUT, 32'd1, 32'd100);
        send_item(ACT_PUT, 32'd2, 32'd200);
        send_item(ACT_GET, 32'd1, 32'd0);
        send_item(ACT_GET, 32'd2, 32'd0);
        send_item(ACT_PUT, 32'd2, 32'd201);
        send_item(ACT_GET, 32'h8000_0000, 32'd0);

        // A capacity of zero behaves as one.
        set_capacity(5'd0);
        send_item(ACT_PUT, 32'd3, 32'd300);
        send_item(ACT_GET, 32'd3, 32'd0);
        send_item(ACT_PUT, 32'd4, 32'd400);
        send_item(ACT_GET, 32'd3, 32'd0);

        set_capacity(5'd1);
        run_phase(40, 4);
        set_capacity(5'd0);
        run_phase(30, 3);
        set_capacity(5'd31);
        run_phase(60, 22);

        // Lowered capacity while the store is nearly full, with a long receiver hold-off.
        set_capacity(5'd3);
        stall_request = 1'b1;
        run_phase(50, 6);

        set_capacity(5'd17);
        steady = 1'b1;
        run_phase(60, 20);
        steady = 1'b0;

        set_capacity(5'd16);
        run_phase(60, 18);
        wait_for_replies();
        run_phase(40, 18);

        set_capacity(5'd8);
        run_phase(50, 12);
        set_capacity(5'd2);
        run_phase(40, 5);
        for (int p = 0; p < 3; p++)
        begin
            set_capacity(5'($urandom_range(31)));
            run_phase(40, $urandom_range(2, 24));
        end

        wait_for_replies();
        repeat (4) @(posedge clk);

        $display("Ran %0d gets and %0d puts over %0d capacity settings.",
                 sb.gets, sb.puts, settings_used);
        $display("Saw %0d key hits and %0d evictions; %0d mismatches.",
                 sb.hits, sb.evictions, sb.errors);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
